FILE: hw/rtl/ifhg_pkg.sv
//------------------------------------------------------------------------------
// ifhg_pkg
// Shared constants and types for the IPv4 fragment header generator.
//------------------------------------------------------------------------------
`default_nettype none

package ifhg_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_FRAME_MTU    = 3'd0;
   localparam logic [2:0] CSR_SOURCE_IP    = 3'd1;
   localparam logic [2:0] CSR_PROTOCOL_ID  = 3'd2;
   localparam logic [2:0] CSR_TTL_WHOLE    = 3'd3;
   localparam logic [2:0] CSR_TTL_FRAGMENT = 3'd4;

   // Reset values
   localparam logic [13:0] MTU_RESET       = 14'd1514;
   localparam logic [7:0]  PROTO_RESET     = 8'd17;
   localparam logic [7:0]  TTL_WHOLE_RESET = 8'd64;
   localparam logic [7:0]  TTL_FRAG_RESET  = 8'd60;

   // MTU clamp window
   localparam logic [13:0] MTU_MIN = 14'd1100;
   localparam logic [13:0] MTU_MAX = 14'd9018;

   // Header sizes
   localparam logic [6:0]  ETH_IP_HDR_BYTES = 7'd34;
   localparam logic [15:0] IP_HDR_BYTES     = 16'd20;
   localparam logic [15:0] VER_IHL_TOS      = 16'h4500;

   // Header word select, in checksum order
   localparam logic [3:0] WORD_VER    = 4'd0;
   localparam logic [3:0] WORD_TOTLEN = 4'd1;
   localparam logic [3:0] WORD_ID     = 4'd2;
   localparam logic [3:0] WORD_FLAGS  = 4'd3;
   localparam logic [3:0] WORD_TTL    = 4'd4;
   localparam logic [3:0] WORD_CSUM   = 4'd5;
   localparam logic [3:0] WORD_SRC_HI = 4'd6;
   localparam logic [3:0] WORD_SRC_LO = 4'd7;
   localparam logic [3:0] WORD_DST_HI = 4'd8;
   localparam logic [3:0] WORD_DST_LO = 4'd9;

   typedef struct packed {
      logic clear;
      logic add;
   } csum_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ifhg_csum.sv
//------------------------------------------------------------------------------
// ifhg_csum
// One's-complement accumulator, one 16-bit word per cycle, end-around carry.
//------------------------------------------------------------------------------
`default_nettype none

module ifhg_csum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ifhg_pkg::csum_ctl_type ctl,
   input  wire logic [15:0]           word,
   output logic [15:0]                checksum
);
   import ifhg_pkg::*;

   logic [15:0] acc_ff, acc_in;
   logic [16:0] raw_sum;

   assign raw_sum = {1'b0, acc_ff} + {1'b0, word};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = 16'd0;
      end else if (ctl.add) begin
         // fold carry back in
         acc_in = raw_sum[15:0] + {15'd0, raw_sum[16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 16'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign checksum = ~acc_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_fragment_header_gen.sv
//------------------------------------------------------------------------------
// ipv4_fragment_header_gen
// Splits one send request into IPv4 fragment descriptors with header checksum.
//------------------------------------------------------------------------------
// Usage:
//   req_*  : one word per send request (message length, upper header length,
//            destination). req_ready is high only while the block is idle.
//   rsp_*  : one word per fragment descriptor; rsp_last marks the final word
//            of a request. Over-length requests give a single word with
//            rsp_error set; zero-length requests give nothing.
//   csr_*  : write-only registers, written while idle.
// Flow:
//   Each fragment passes through a setup state for the slice arithmetic,
//   the shared checksum adder (fed the ten header words in turn) and an
//   output state. A request gives at most 62 fragments, at the smallest MTU.
// Reset: registers go to their defaults, datagram id to 0, block idle.
// Stall: a descriptor holds on rsp_* until taken; the sequencer waits.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4_fragment_header_gen (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_message_length,
   input  wire logic [5:0]  req_upper_header_length,
   input  wire logic [31:0] req_dest_ip,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_datagram_id,
   output logic [12:0]      rsp_offset_units,
   output logic             rsp_more_fragments,
   output logic [7:0]       rsp_time_to_live,
   output logic [15:0]      rsp_ip_total_length,
   output logic [15:0]      rsp_payload_start,
   output logic [13:0]      rsp_payload_length,
   output logic [6:0]       rsp_frame_header_length,
   output logic [15:0]      rsp_header_checksum,
   output logic             rsp_error,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import ifhg_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_SUM   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // config registers
   logic [13:0] mtu_cfg_ff, mtu_cfg_in;
   logic [31:0] src_ff, src_in;
   logic [7:0]  proto_ff, proto_in;
   logic [7:0]  ttl_whole_ff, ttl_whole_in;
   logic [7:0]  ttl_frag_ff, ttl_frag_in;

   // sequencer
   logic [1:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [15:0] id_ff, id_in;
   logic        err_ff, err_in;
   logic        first_ff, first_in;

   // per-request context
   logic [13:0] mtu_ff, mtu_in;     // clamped MTU
   logic [13:0] trim_ff, trim_in;   // IP payload of a non-final fragment
   logic [5:0]  uhl_ff, uhl_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] start_ff, start_in;
   logic [12:0] off_ff, off_in;

   // current fragment
   logic [15:0] body_ff, body_in;
   logic [15:0] ipb_ff, ipb_in;
   logic        mf_ff, mf_in;
   logic [6:0]  hdr_ff, hdr_in;

   logic        req_fire;
   logic        rsp_fire;
   logic [16:0] dgram_len;
   logic [13:0] mtu_clamp;
   logic [13:0] mtu_less_hdr;
   logic [5:0]  phl;
   logic [6:0]  hdr_calc;
   logic [13:0] room;
   logic        mf_calc;
   logic [7:0]  ttl_cur;
   logic [15:0] tot_cur;
   logic [15:0] word_sel;
   logic [15:0] checksum;

   csum_ctl_type csum_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // over-length: 20 + message + upper header beyond 16 bits
   assign dgram_len = {1'b0, req_message_length} + {11'd0, req_upper_header_length}
                      + {1'b0, IP_HDR_BYTES};

   assign mtu_clamp = (mtu_cfg_ff < MTU_MIN) ? MTU_MIN :
                      (mtu_cfg_ff > MTU_MAX) ? MTU_MAX : mtu_cfg_ff;
   assign mtu_less_hdr = mtu_clamp - {7'd0, ETH_IP_HDR_BYTES};

   // slice arithmetic for the setup cycle
   assign phl      = first_ff ? uhl_ff : 6'd0;
   assign hdr_calc = ETH_IP_HDR_BYTES + {1'b0, phl};
   assign room     = mtu_ff - {7'd0, hdr_calc};
   assign mf_calc  = remain_ff > {2'd0, room};

   assign ttl_cur = mf_ff ? ttl_frag_ff : ttl_whole_ff;
   assign tot_cur = ipb_ff + IP_HDR_BYTES;

   // header word feeding the checksum adder
   always_comb begin
      case (step_ff)
         WORD_VER:    word_sel = VER_IHL_TOS;
         WORD_TOTLEN: word_sel = tot_cur;
         WORD_ID:     word_sel = id_ff;
         WORD_FLAGS:  word_sel = {2'b00, mf_ff, off_ff};
         WORD_TTL:    word_sel = {ttl_cur, proto_ff};
         WORD_CSUM:   word_sel = 16'd0;
         WORD_SRC_HI: word_sel = src_ff[31:16];
         WORD_SRC_LO: word_sel = src_ff[15:0];
         WORD_DST_HI: word_sel = dst_ff[31:16];
         WORD_DST_LO: word_sel = dst_ff[15:0];
         default:     word_sel = 16'd0;
      endcase
   end

   assign csum_ctl.clear = (state_ff == ST_SETUP);
   assign csum_ctl.add   = (state_ff == ST_SUM);

   ifhg_csum u_csum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (csum_ctl),
      .word     (word_sel),
      .checksum (checksum)
   );

   // config writes
   always_comb begin
      mtu_cfg_in   = mtu_cfg_ff;
      src_in       = src_ff;
      proto_in     = proto_ff;
      ttl_whole_in = ttl_whole_ff;
      ttl_frag_in  = ttl_frag_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_MTU:    mtu_cfg_in   = csr_wdata[13:0];
            CSR_SOURCE_IP:    src_in       = csr_wdata;
            CSR_PROTOCOL_ID:  proto_in     = csr_wdata[7:0];
            CSR_TTL_WHOLE:    ttl_whole_in = csr_wdata[7:0];
            CSR_TTL_FRAGMENT: ttl_frag_in  = csr_wdata[7:0];
            default:          ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      id_in     = id_ff;
      err_in    = err_ff;
      first_in  = first_ff;
      mtu_in    = mtu_ff;
      trim_in   = trim_ff;
      uhl_in    = uhl_ff;
      dst_in    = dst_ff;
      remain_in = remain_ff;
      start_in  = start_ff;
      off_in    = off_ff;
      body_in   = body_ff;
      ipb_in    = ipb_ff;
      mf_in     = mf_ff;
      hdr_in    = hdr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_message_length != 16'd0)) begin
               mtu_in    = mtu_clamp;
               trim_in   = {mtu_less_hdr[13:3], 3'b000};
               uhl_in    = req_upper_header_length;
               dst_in    = req_dest_ip;
               remain_in = req_message_length;
               start_in  = 16'd0;
               off_in    = 13'd0;
               first_in  = 1'b1;
               err_in    = dgram_len[16];
               state_in  = dgram_len[16] ? ST_EMIT : ST_SETUP;
            end
         end
         ST_SETUP: begin
            hdr_in = hdr_calc;
            mf_in  = mf_calc;
            if (mf_calc) begin
               // non-final: IP payload trimmed to 8-byte multiple
               ipb_in  = {2'd0, trim_ff};
               body_in = {2'd0, trim_ff} - {10'd0, phl};
            end else begin
               ipb_in  = remain_ff + {10'd0, phl};
               body_in = remain_ff;
            end
            step_in  = WORD_VER;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            step_in = step_ff + 4'd1;
            if (step_ff == WORD_DST_LO) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (err_ff) begin
                  state_in = ST_IDLE;
               end else if (!mf_ff) begin
                  id_in    = id_ff + 16'd1;
                  state_in = ST_IDLE;
               end else begin
                  remain_in = remain_ff - body_ff;
                  start_in  = start_ff + body_ff;
                  off_in    = off_ff + ipb_ff[15:3];
                  first_in  = 1'b0;
                  state_in  = ST_SETUP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_cfg_ff   <= MTU_RESET;
         src_ff       <= 32'd0;
         proto_ff     <= PROTO_RESET;
         ttl_whole_ff <= TTL_WHOLE_RESET;
         ttl_frag_ff  <= TTL_FRAG_RESET;
         state_ff     <= ST_IDLE;
         step_ff      <= WORD_VER;
         id_ff        <= 16'd0;
         err_ff       <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         mtu_cfg_ff   <= mtu_cfg_in;
         src_ff       <= src_in;
         proto_ff     <= proto_in;
         ttl_whole_ff <= ttl_whole_in;
         ttl_frag_ff  <= ttl_frag_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         id_ff        <= id_in;
         err_ff       <= err_in;
         first_ff     <= first_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      mtu_ff    <= mtu_in;
      trim_ff   <= trim_in;
      uhl_ff    <= uhl_in;
      dst_ff    <= dst_in;
      remain_ff <= remain_in;
      start_ff  <= start_in;
      off_ff    <= off_in;
      body_ff   <= body_in;
      ipb_ff    <= ipb_in;
      mf_ff     <= mf_in;
      hdr_ff    <= hdr_in;
   end

   // result word; error word is all zero but error and last
   assign rsp_datagram_id         = err_ff ? 16'd0 : id_ff;
   assign rsp_offset_units        = err_ff ? 13'd0 : off_ff;
   assign rsp_more_fragments      = err_ff ? 1'b0  : mf_ff;
   assign rsp_time_to_live        = err_ff ? 8'd0  : ttl_cur;
   assign rsp_ip_total_length     = err_ff ? 16'd0 : tot_cur;
   assign rsp_payload_start       = err_ff ? 16'd0 : start_ff;
   assign rsp_payload_length      = err_ff ? 14'd0 : body_ff[13:0];
   assign rsp_frame_header_length = err_ff ? 7'd0  : hdr_ff;
   assign rsp_header_checksum     = err_ff ? 16'd0 : checksum;
   assign rsp_error               = err_ff;
   assign rsp_last                = err_ff || !mf_ff;

endmodule

`default_nettype wire

FILE: tb/sv/ipv4_fragment_header_gen_tb.sv
//------------------------------------------------------------------------------
// ipv4_fragment_header_gen_tb
// Self-checking bench for the IPv4 fragment header generator. Every accepted
// send request is expanded in the bench into the fragment descriptors that
// the block is due to emit. Each descriptor word the block hands out is
// checked in order against them. Directed cases cover the fragment edges,
// the length limits and the register extremes. Random traffic follows, under
// several register settings, with random stalls on both channels.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4_fragment_header_gen_tb;
   import ifhg_pkg::*;

   localparam int          CLK_PERIOD   = 12;
   localparam int          RESET_CYCLES = 11;
   localparam logic [15:0] MF_FLAG      = 16'h2000;
   localparam int          FRAG_LIMIT   = 64;  // descriptors per request, at most
   localparam int          IP_MAX_BYTES = 65535;
   localparam int          IDLE_PCT     = 29;
   localparam int          SETTLE_CYC   = 30;  // settle time after the last owed word is in
   localparam int          REPORT_MAX   = 10;
   localparam int          RAND_PHASES  = 6;
   localparam int          PHASE_ITEMS  = 52;

   // One descriptor word as seen on rsp_*
   typedef struct packed {
      logic [15:0] datagram_id;
      logic [12:0] offset_units;
      logic        more_fragments;
      logic [7:0]  time_to_live;
      logic [15:0] ip_total_length;
      logic [15:0] payload_start;
      logic [13:0] payload_length;
      logic [6:0]  frame_header_length;
      logic [15:0] header_checksum;
      logic        error;
      logic        last;
   } frag_desc_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_message_length = '0;
   logic [5:0]  req_upper_header_length = '0;
   logic [31:0] req_dest_ip = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_datagram_id;
   logic [12:0] rsp_offset_units;
   logic        rsp_more_fragments;
   logic [7:0]  rsp_time_to_live;
   logic [15:0] rsp_ip_total_length;
   logic [15:0] rsp_payload_start;
   logic [13:0] rsp_payload_length;
   logic [6:0]  rsp_frame_header_length;
   logic [15:0] rsp_header_checksum;
   logic        rsp_error;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Bench copy of the registers and the datagram id counter
   logic [13:0] mtu_cfg       = MTU_RESET;
   logic [31:0] src_ip_cfg    = '0;
   logic [7:0]  proto_cfg     = PROTO_RESET;
   logic [7:0]  ttl_whole_cfg = TTL_WHOLE_RESET;
   logic [7:0]  ttl_frag_cfg  = TTL_FRAG_RESET;
   logic [15:0] next_id       = '0;

   frag_desc_type pending_frags[$];   // descriptors still owed by the block
   int          mismatch_count = 0;
   bit          no_idle = 1'b0;     // set for a stretch with no stalls at all

   ipv4_fragment_header_gen dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_message_length      (req_message_length),
      .req_upper_header_length (req_upper_header_length),
      .req_dest_ip             (req_dest_ip),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_datagram_id         (rsp_datagram_id),
      .rsp_offset_units        (rsp_offset_units),
      .rsp_more_fragments      (rsp_more_fragments),
      .rsp_time_to_live        (rsp_time_to_live),
      .rsp_ip_total_length     (rsp_ip_total_length),
      .rsp_payload_start       (rsp_payload_start),
      .rsp_payload_length      (rsp_payload_length),
      .rsp_frame_header_length (rsp_frame_header_length),
      .rsp_header_checksum     (rsp_header_checksum),
      .rsp_error               (rsp_error),
      .rsp_last                (rsp_last),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop. Worst case is far below this: 332 requests of 64 fragments,
   // each fragment held up further by receiver stalls.
   initial begin
      #(CLK_PERIOD * 3_000_000);
      $display("ipv4_fragment_header_gen test failed");
      $finish;
   end

   //---------------------------------------------------------------------------
   // Expected descriptors for one request. Splits the message over frames of
   // the clamped MTU; the first frame also carries the upper header, and every
   // frame but the last has its IP payload cut back to a multiple of 8.
   //---------------------------------------------------------------------------
   function automatic void expand_request(input logic [15:0] msg_len,
                                          input logic [5:0]  uhl,
                                          input logic [31:0] dst);
      frag_desc_type d;
      logic [31:0] mtu, remain, start, offu, phl, hdr, room, body, ipb;
      logic [31:0] ttl, tot, flags_word, acc;
      logic        mf;
      int          count;

      // zero length: nothing comes out and the id is kept
      if (msg_len == 0)
         return;

      // over length: one error word, every other field zero, id kept
      if (32'(IP_HDR_BYTES) + msg_len + uhl > IP_MAX_BYTES) begin
         d       = '0;
         d.error = 1'b1;
         d.last  = 1'b1;
         pending_frags.push_back(d);
         return;
      end

      mtu = mtu_cfg;
      if (mtu < MTU_MIN) mtu = MTU_MIN;
      if (mtu > MTU_MAX) mtu = MTU_MAX;

      remain = msg_len;
      start  = 0;
      offu   = 0;
      count  = 0;
      while (remain > 0 && count < FRAG_LIMIT) begin
         phl  = (count == 0) ? uhl : 0;
         hdr  = ETH_IP_HDR_BYTES + phl;
         room = mtu - hdr;
         body = (remain < room) ? remain : room;
         ipb  = body + phl;
         mf   = (remain != body);
         if (mf) begin
            body = body - (ipb % 8);
            ipb  = ipb - (ipb % 8);
         end
         ttl        = mf ? ttl_frag_cfg : ttl_whole_cfg;
         tot        = (IP_HDR_BYTES + ipb) & 32'hFFFF;
         flags_word = (offu & 32'h1FFF) | (mf ? MF_FLAG : 16'h0);

         // ones-complement sum of the ten header words, checksum word as zero
         acc = VER_IHL_TOS + tot + next_id + flags_word + ((ttl << 8) | proto_cfg)
             + src_ip_cfg[31:16] + src_ip_cfg[15:0] + dst[31:16] + dst[15:0];
         while (acc > 32'hFFFF)
            acc = (acc & 32'hFFFF) + (acc >> 16);

         d.datagram_id         = next_id;
         d.offset_units        = offu[12:0];
         d.more_fragments      = mf;
         d.time_to_live        = ttl[7:0];
         d.ip_total_length     = tot[15:0];
         d.payload_start       = start[15:0];
         d.payload_length      = body[13:0];
         d.frame_header_length = hdr[6:0];
         d.header_checksum     = ~acc[15:0];
         d.error               = 1'b0;
         d.last                = !mf || (count == FRAG_LIMIT - 1);
         pending_frags.push_back(d);

         count  = count + 1;
         start  = start + body;
         offu   = offu + ipb / 8;
         remain = remain - body;
      end
      next_id = next_id + 16'd1;
   endfunction

   function automatic string desc_text(input frag_desc_type d);
      return $sformatf({"id=%h off=%0d mf=%b ttl=%0d tot=%0d start=%0d len=%0d ",
                        "fhl=%0d csum=%h err=%b last=%b"},
                       d.datagram_id, d.offset_units, d.more_fragments,
                       d.time_to_live, d.ip_total_length, d.payload_start,
                       d.payload_length, d.frame_header_length,
                       d.header_checksum, d.error, d.last);
   endfunction

   //---------------------------------------------------------------------------
   // Receiver: random stalls, sampled at the edge like the block does
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // Checks every descriptor word taken against the oldest one owed
   always @(posedge clock) begin
      frag_desc_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_datagram_id, rsp_offset_units, rsp_more_fragments,
                 rsp_time_to_live, rsp_ip_total_length, rsp_payload_start,
                 rsp_payload_length, rsp_frame_header_length,
                 rsp_header_checksum, rsp_error, rsp_last};
         if (pending_frags.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected word: %s", desc_text(got));
         end else begin
            want = pending_frags.pop_front();
            if (got !== want) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch expected: %s", desc_text(want));
                  $display("         actual:   %s", desc_text(got));
               end
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Sender
   //---------------------------------------------------------------------------
   // Valid stays up between back-to-back requests; it only drops in a gap or
   // when a test hands the channel back through wait_drained.
   task automatic send_request(input logic [15:0] msg_len, input logic [5:0] uhl,
                               input logic [31:0] dst);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT)
            @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_message_length      <= msg_len;
      req_upper_header_length <= uhl;
      req_dest_ip             <= dst;
      do
         @(posedge clock);
      while (!req_ready);
      expand_request(msg_len, uhl, dst);
   endtask

   // Sender drops valid and holds off until every owed word is in, then lets
   // the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frags.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_MTU:    mtu_cfg       = value[13:0];
         CSR_SOURCE_IP:    src_ip_cfg    = value;
         CSR_PROTOCOL_ID:  proto_cfg     = value[7:0];
         CSR_TTL_WHOLE:    ttl_whole_cfg = value[7:0];
         CSR_TTL_FRAGMENT: ttl_frag_cfg  = value[7:0];
         default: ;
      endcase
   endtask

   // Upper bits of the narrow registers are filled with junk; the block
   // must ignore them.
   task automatic apply_settings(input logic [13:0] mtu, input logic [31:0] src,
                                 input logic [7:0] proto, input logic [7:0] ttl_w,
                                 input logic [7:0] ttl_f);
      wait_drained();
      write_csr(CSR_FRAME_MTU,    {18'($urandom), mtu});
      write_csr(CSR_SOURCE_IP,    src);
      write_csr(CSR_PROTOCOL_ID,  {24'($urandom), proto});
      write_csr(CSR_TTL_WHOLE,    {24'($urandom), ttl_w});
      write_csr(CSR_TTL_FRAGMENT, {24'($urandom), ttl_f});
   endtask

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------
   // Reset settings (1514 MTU): single frame, exact fit, one byte over, and
   // the upper header pushing a request into two fragments.
   task automatic test_fragment_boundaries();
      send_request(16'd0,    6'd0,  32'h0000_0000);   // zero length
      send_request(16'd1,    6'd0,  32'hFFFF_FFFF);
      send_request(16'd1480, 6'd0,  32'hAAAA_AAAA);   // fills the frame exactly
      send_request(16'd1481, 6'd0,  32'h5555_5555);   // one byte spills over
      send_request(16'd1480, 6'd8,  32'h0123_4567);
      send_request(16'd1483, 6'd3,  32'h89AB_CDEF);   // trim with odd header
      send_request(16'd0,    6'd60, 32'hFFFF_FFFF);   // zero length again
      send_request(16'd4000, 6'd59, 32'hC0A8_0001);
   endtask

   // Datagram just under and just over the 64 KiB IP limit
   task automatic test_length_limits();
      send_request(16'd65515, 6'd0,  32'h0A00_0001);  // largest legal
      send_request(16'd65516, 6'd0,  32'h0A00_0002);  // one over: error word
      send_request(16'd65455, 6'd60, 32'h0A00_0003);
      send_request(16'd65456, 6'd60, 32'h0A00_0004);
      send_request(16'd65535, 6'd60, 32'hFFFF_FFFF);
   endtask

   // MTU below, at and above the clamp window, all-ones addresses for the
   // end-around carry, and the TTL and protocol extremes.
   task automatic test_register_extremes();
      apply_settings(14'd0, 32'hFFFF_FFFF, 8'hFF, 8'd255, 8'd255);
      send_request(16'd5000, 6'd60, 32'hFFFF_FFFF);
      send_request(16'd2,    6'd0,  32'h0000_0000);
      apply_settings(14'd1099, 32'h0000_0000, 8'h00, 8'd1, 8'd1);
      send_request(16'd3000, 6'd1, 32'h8000_0001);
      apply_settings(14'd9018, 32'h7F00_0001, 8'd6, 8'd128, 8'd2);
      send_request(16'd8984, 6'd0,  32'h7F00_0002);   // exact fit at top MTU
      send_request(16'd20000, 6'd60, 32'hDEAD_BEEF);
      apply_settings(14'd16383, 32'h1234_5678, 8'd1, 8'd200, 8'd100);
      send_request(16'd9000, 6'd7, 32'h8765_4321);
      apply_settings(14'd1100, 32'hC0A8_0A0A, 8'd17, 8'd64, 8'd60);
      send_request(16'd65515, 6'd0, 32'hC0A8_0A0B);   // most fragments
   endtask

   // Random requests in phases, each under fresh register settings. One
   // phase runs with no stalls on either side.
   task automatic test_random_traffic();
      logic [13:0] mtu;
      logic [15:0] len;
      logic [5:0]  uhl;
      int          pick;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case ($urandom_range(3))
            0: mtu = 14'($urandom_range(MTU_MAX, MTU_MIN));
            1: mtu = 14'($urandom);
            2: mtu = MTU_MIN;
            default: mtu = MTU_MAX;
         endcase
         apply_settings(mtu, $urandom, 8'($urandom), 8'($urandom_range(255, 1)),
                        8'($urandom_range(255, 1)));
         no_idle = (phase == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            uhl  = 6'($urandom_range(60));
            pick = $urandom_range(99);
            if (pick < 3)
               len = 16'd0;
            else if (pick < 8)
               len = 16'($urandom_range(65535, 65516 - uhl));   // over length
            else if (pick < 18)
               len = 16'($urandom_range(65515 - uhl, 1));
            else if (pick < 48)
               len = 16'($urandom_range(20000, 1));
            else
               len = 16'($urandom_range(3000, 1));
            send_request(len, uhl, $urandom);
         end
         no_idle = 1'b0;
      end
   endtask

   //---------------------------------------------------------------------------
   // Sequence
   //---------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fragment_boundaries();
      test_length_limits();
      test_register_extremes();
      test_random_traffic();
      wait_drained();

      if (mismatch_count == 0 && pending_frags.size() == 0) begin
         $display("ipv4_fragment_header_gen test passed");
      end else begin
         $display("ipv4_fragment_header_gen test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
